### hdl/sine_tone_with_linear_fade_top_defines.svh
// Assertion macros for the tone generator top level.
`ifndef SINE_TONE_WITH_LINEAR_FADE_TOP_DEFINES_SVH
`define SINE_TONE_WITH_LINEAR_FADE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while in reset.
`define STWF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stwf assertion failed");

// Next-cycle implication, sampled on clk, disabled while in reset.
`define STWF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stwf assertion failed");

`endif

### hdl/stwf_pkg.sv
// Shared types, constants and microcode program of the tone generator.
package stwf_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_SHIFT      = 16 - SINE_TABLE_BITS;
    localparam int LEN_W           = 24;
    localparam int OPND_W          = 29;
    localparam int PROD_W          = 2 * OPND_W;
    localparam int MAG_W           = 15;
    localparam int FADE_W          = 16;
    localparam int DIVD_W          = MAG_W + FADE_W;
    localparam int CNT_W           = 5;
    localparam int PADDR_W         = 4;

    localparam logic [CNT_W-1:0]  DIV_LAST_CNT = CNT_W'(DIVD_W - 1);
    localparam logic [CNT_W-1:0]  POLY_CNT     = CNT_W'(3);
    localparam logic [OPND_W-1:0] Q28_ONE      = OPND_W'(29'h1000_0000);
    localparam logic [14:0]       QUARTER      = 15'd16384;

    localparam logic [OPND_W-1:0] POLY_C1 = OPND_W'(421657428);
    localparam logic [OPND_W-1:0] POLY_C3 = OPND_W'(173399667);
    localparam logic [OPND_W-1:0] POLY_C5 = OPND_W'(21392326);
    localparam logic [OPND_W-1:0] POLY_C7 = OPND_W'(1256748);
    localparam logic [OPND_W-1:0] POLY_C9 = OPND_W'(43068);

    typedef enum logic [1:0] {
        REG_PHASE_STEP  = 2'd0,
        REG_TONE_LENGTH = 2'd1,
        REG_FADE_LENGTH = 2'd2,
        REG_AMPLITUDE   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [15:0]       phase_step;
        logic [LEN_W-1:0]  tone_length;
        logic [FADE_W-1:0] fade_length;
        logic [MAG_W-1:0]  amplitude;
    } cfg_t;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_WAIT,
        UOP_SETUP,
        UOP_MUL_XX,
        UOP_LD_X2,
        UOP_MUL_TX2,
        UOP_SUB_C,
        UOP_MUL_TX,
        UOP_CLAMP,
        UOP_MUL_AMP,
        UOP_MAG,
        UOP_MUL_K,
        UOP_LD_DIV,
        UOP_DIV,
        UOP_EMIT,
        UOP_FIN
    } uop_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NOT_ACCEPT,
        C_FINISHED,
        C_NO_FADE,
        C_CNT,
        C_OUT_BUSY
    } cond_t;

    typedef logic [4:0] pc_t;

    localparam pc_t S_WAIT    = 5'd0;
    localparam pc_t S_SETUP   = 5'd1;
    localparam pc_t S_MUL_XX  = 5'd2;
    localparam pc_t S_LD_X2   = 5'd3;
    localparam pc_t S_MUL_TX2 = 5'd4;
    localparam pc_t S_SUB_C   = 5'd5;
    localparam pc_t S_MUL_TX  = 5'd6;
    localparam pc_t S_CLAMP   = 5'd7;
    localparam pc_t S_MUL_AMP = 5'd8;
    localparam pc_t S_MAG     = 5'd9;
    localparam pc_t S_MUL_K   = 5'd10;
    localparam pc_t S_LD_DIV  = 5'd11;
    localparam pc_t S_DIV     = 5'd12;
    localparam pc_t S_EMIT    = 5'd13;
    localparam pc_t S_RET     = 5'd14;
    localparam pc_t S_FIN     = 5'd15;
    localparam pc_t S_FIN_RET = 5'd16;
    localparam pc_t S_LAST    = S_FIN_RET;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        pc_t   target;
    } ctrl_t;

    typedef struct packed {
        logic accept;
        logic finished;
        logic no_fade;
        logic cnt_nz;
        logic out_busy;
    } stat_t;

    function automatic ctrl_t ucode(pc_t addr);
        ctrl_t w;
        unique case (addr)
            S_WAIT:    w = '{UOP_WAIT,    C_NOT_ACCEPT, S_WAIT};
            S_SETUP:   w = '{UOP_SETUP,   C_FINISHED,   S_FIN};
            S_MUL_XX:  w = '{UOP_MUL_XX,  C_NEXT,       S_WAIT};
            S_LD_X2:   w = '{UOP_LD_X2,   C_NEXT,       S_WAIT};
            S_MUL_TX2: w = '{UOP_MUL_TX2, C_NEXT,       S_WAIT};
            S_SUB_C:   w = '{UOP_SUB_C,   C_CNT,        S_MUL_TX2};
            S_MUL_TX:  w = '{UOP_MUL_TX,  C_NEXT,       S_WAIT};
            S_CLAMP:   w = '{UOP_CLAMP,   C_NEXT,       S_WAIT};
            S_MUL_AMP: w = '{UOP_MUL_AMP, C_NEXT,       S_WAIT};
            S_MAG:     w = '{UOP_MAG,     C_NO_FADE,    S_EMIT};
            S_MUL_K:   w = '{UOP_MUL_K,   C_NEXT,       S_WAIT};
            S_LD_DIV:  w = '{UOP_LD_DIV,  C_NEXT,       S_WAIT};
            S_DIV:     w = '{UOP_DIV,     C_CNT,        S_DIV};
            S_EMIT:    w = '{UOP_EMIT,    C_OUT_BUSY,   S_EMIT};
            S_RET:     w = '{UOP_NOP,     C_ALWAYS,     S_WAIT};
            S_FIN:     w = '{UOP_FIN,     C_OUT_BUSY,   S_FIN};
            S_FIN_RET: w = '{UOP_NOP,     C_ALWAYS,     S_WAIT};
            default:   w = '{UOP_NOP,     C_ALWAYS,     S_WAIT};
        endcase
        return w;
    endfunction

    // Horner coefficients, highest remaining degree first as the count runs down.
    function automatic logic [OPND_W-1:0] poly_coef(logic [1:0] sel);
        logic [OPND_W-1:0] c;
        case (sel)
            2'd3:    c = POLY_C7;
            2'd2:    c = POLY_C5;
            2'd1:    c = POLY_C3;
            default: c = POLY_C1;
        endcase
        return c;
    endfunction

endpackage

### hdl/stwf_if.sv
// Handshake channel interfaces for tick requests and sample results.
interface stwf_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface stwf_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample;
    logic        last_sample;
    logic        finished;

    modport source (output valid, output sample, output last_sample, output finished,
                    input ready);
    modport sink   (input valid, input sample, input last_sample, input finished,
                    output ready);
endinterface

### hdl/stwf_cfg.sv
// APB configuration register file of the tone generator.
module stwf_cfg
    import stwf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_PHASE_STEP:  cfg_next.phase_step  = pwdata[15:0];
                REG_TONE_LENGTH: cfg_next.tone_length = pwdata[LEN_W-1:0];
                REG_FADE_LENGTH: cfg_next.fade_length = pwdata[FADE_W-1:0];
                REG_AMPLITUDE:   cfg_next.amplitude   = pwdata[MAG_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_PHASE_STEP:  prdata = {16'd0, cfg_reg.phase_step};
            REG_TONE_LENGTH: prdata = {8'd0, cfg_reg.tone_length};
            REG_FADE_LENGTH: prdata = {16'd0, cfg_reg.fade_length};
            REG_AMPLITUDE:   prdata = {17'd0, cfg_reg.amplitude};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step  <= 16'd1802;
            cfg_reg.tone_length <= 24'd3200;
            cfg_reg.fade_length <= 16'd800;
            cfg_reg.amplitude   <= 15'd8000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/stwf_useq.sv
// Microcode sequencer: step counter, control ROM and branch logic.
module stwf_useq
    import stwf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctrl_t ctrl,
    output pc_t   pc
);

    pc_t  pc_reg;
    pc_t  pc_next;
    logic take;

    assign ctrl = ucode(pc_reg);
    assign pc   = pc_reg;

    always_comb
    begin
        case (ctrl.cond)
            C_ALWAYS:     take = 1'b1;
            C_NOT_ACCEPT: take = !stat.accept;
            C_FINISHED:   take = stat.finished;
            C_NO_FADE:    take = stat.no_fade;
            C_CNT:        take = stat.cnt_nz;
            C_OUT_BUSY:   take = stat.out_busy;
            default:      take = 1'b0;
        endcase
        pc_next = take ? ctrl.target : pc_t'(pc_reg + 5'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

### hdl/stwf_dp.sv
// Datapath: phase and index state, shared multiplier, serial fade divider, result register.
module stwf_dp
    import stwf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ctrl_t     ctrl,
    input  cfg_t      cfg,
    output stat_t     stat,
    stwf_in_if.sink   tick,
    stwf_out_if.source result
);

    logic [15:0]       phase_reg;
    logic [LEN_W-1:0]  idx_reg;
    logic [14:0]       x_reg;
    logic              neg_reg;
    logic [OPND_W-1:0] x2_reg;
    logic [OPND_W-1:0] t_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic [FADE_W-1:0] k_reg;
    logic              fade_en_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIVD_W-1:0] div_reg;
    logic [FADE_W-1:0] rem_reg;
    logic              out_valid_reg;
    logic [15:0]       sample_reg;
    logic              last_reg;
    logic              fin_reg;

    logic [OPND_W-1:0] mul_a;
    logic [OPND_W-1:0] mul_b;
    logic [15:0]       p_trunc;
    logic [13:0]       p_frac;
    logic              finished;
    logic              fade_nz;
    logic              fade_in;
    logic              fade_out;
    logic [LEN_W-1:0]  fade_ext;
    logic [LEN_W-1:0]  remain;
    logic              out_busy;
    logic              accept;
    logic [OPND_W:0]   sub_res;
    logic [OPND_W:0]   s_val;
    logic [FADE_W:0]   trial;
    logic              q_bit;
    logic [MAG_W-1:0]  mag_fin;
    logic [LEN_W-1:0]  idx_inc;

    assign accept   = tick.valid && tick.ready;
    assign out_busy = out_valid_reg && !result.ready;
    assign finished = idx_reg >= cfg.tone_length;
    assign fade_ext = LEN_W'(cfg.fade_length);
    assign fade_nz  = cfg.fade_length != '0;
    assign remain   = cfg.tone_length - idx_reg;
    assign fade_in  = fade_nz && (idx_reg < fade_ext);
    assign fade_out = fade_nz && (cfg.tone_length >= fade_ext)
                      && (idx_reg > (cfg.tone_length - fade_ext));
    assign p_trunc  = (phase_reg >> SINE_SHIFT) << SINE_SHIFT;
    assign p_frac   = p_trunc[13:0];
    assign sub_res  = {1'b0, poly_coef(cnt_reg[1:0])} - prod_reg[PROD_W-1:28];
    assign s_val    = prod_reg[OPND_W+14:14];
    assign trial    = {rem_reg, div_reg[DIVD_W-1]};
    assign q_bit    = trial >= {1'b0, cfg.fade_length};
    assign mag_fin  = fade_en_reg ? div_reg[MAG_W-1:0] : mag_reg;
    assign idx_inc  = idx_reg + 1'b1;

    assign tick.ready = ctrl.op == UOP_WAIT;

    assign stat.accept   = accept;
    assign stat.finished = finished;
    assign stat.no_fade  = !fade_en_reg;
    assign stat.cnt_nz   = cnt_reg != '0;
    assign stat.out_busy = out_busy;

    assign result.valid       = out_valid_reg;
    assign result.sample      = sample_reg;
    assign result.last_sample = last_reg;
    assign result.finished    = fin_reg;

    always_comb
    begin
        case (ctrl.op)
            UOP_MUL_XX:
            begin
                mul_a = OPND_W'(x_reg);
                mul_b = OPND_W'(x_reg);
            end
            UOP_MUL_TX2:
            begin
                mul_a = t_reg;
                mul_b = x2_reg;
            end
            UOP_MUL_TX:
            begin
                mul_a = t_reg;
                mul_b = OPND_W'(x_reg);
            end
            UOP_MUL_AMP:
            begin
                mul_a = t_reg;
                mul_b = OPND_W'(cfg.amplitude);
            end
            default:
            begin
                mul_a = OPND_W'(mag_reg);
                mul_b = OPND_W'(k_reg);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            UOP_SETUP:
            begin
                x_reg       <= p_trunc[14] ? (QUARTER - {1'b0, p_frac}) : {1'b0, p_frac};
                neg_reg     <= p_trunc[15];
                t_reg       <= POLY_C9;
                fade_en_reg <= fade_in || fade_out;
                k_reg       <= fade_in ? idx_reg[FADE_W-1:0] : remain[FADE_W-1:0];
            end
            UOP_MUL_XX, UOP_MUL_TX2, UOP_MUL_TX, UOP_MUL_AMP, UOP_MUL_K:
            begin
                prod_reg <= mul_a * mul_b;
            end
            UOP_LD_X2:
            begin
                x2_reg <= prod_reg[OPND_W-1:0];
            end
            UOP_SUB_C:
            begin
                t_reg <= sub_res[OPND_W-1:0];
            end
            UOP_CLAMP:
            begin
                t_reg <= (s_val > {1'b0, Q28_ONE}) ? Q28_ONE : s_val[OPND_W-1:0];
            end
            UOP_MAG:
            begin
                mag_reg <= prod_reg[MAG_W+27:28];
            end
            UOP_LD_DIV:
            begin
                div_reg <= prod_reg[DIVD_W-1:0];
                rem_reg <= '0;
            end
            UOP_DIV:
            begin
                div_reg <= {div_reg[DIVD_W-2:0], q_bit};
                rem_reg <= q_bit ? FADE_W'(trial - {1'b0, cfg.fade_length}) : trial[FADE_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            sample_reg    <= '0;
            last_reg      <= 1'b0;
            fin_reg       <= 1'b0;
        end
        else
        begin
            if ((ctrl.op == UOP_EMIT || ctrl.op == UOP_FIN) && !out_busy)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (ctrl.op)
                UOP_WAIT:
                begin
                    if (accept && tick.restart)
                    begin
                        phase_reg <= '0;
                        idx_reg   <= '0;
                    end
                end
                UOP_SETUP:
                begin
                    cnt_reg <= POLY_CNT;
                end
                UOP_LD_DIV:
                begin
                    cnt_reg <= DIV_LAST_CNT;
                end
                UOP_SUB_C, UOP_DIV:
                begin
                    if (cnt_reg != '0)
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                UOP_EMIT:
                begin
                    if (!out_busy)
                    begin
                        sample_reg    <= neg_reg ? (16'd0 - {1'b0, mag_fin}) : {1'b0, mag_fin};
                        last_reg      <= idx_inc == cfg.tone_length;
                        fin_reg       <= 1'b0;
                        phase_reg     <= phase_reg + cfg.phase_step;
                        idx_reg       <= idx_inc;
                    end
                end
                UOP_FIN:
                begin
                    if (!out_busy)
                    begin
                        sample_reg    <= '0;
                        last_reg      <= 1'b0;
                        fin_reg       <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

### hdl/sine_tone_with_linear_fade_top.sv
// Sine tone generator with linear fade-in and fade-out: top level.
//
// tick channel: one transfer asks for one sample; restart=1 clears phase and
// sample index before that sample is made.
// result channel: one transfer per tick carrying sample, last_sample and
// finished. After tone_length samples every tick returns finished with zero.
// APB port: phase_step at 0x0, tone_length at 0x4, fade_length at 0x8,
// amplitude at 0xC; write only while no tick is in flight.
// Sequencing: a microcoded sequencer runs one step per cycle over a shared
// 29x29 multiplier. A faded sample adds the bit-serial divider, 31 steps
// plus 2 setup steps, to the work of a sample outside the fades; a
// finished tick goes from setup straight to the finish step. tick ready
// returns through a return step after the result is loaded, so a new tick
// is taken only once the last one's result is in the output register.
// A held result waits in the output register; the sequencer takes the next
// tick, computes it and stalls at the output step until the receiver takes
// the held one.
// Reset clears phase, index and the output register and restores the
// register defaults.
`include "sine_tone_with_linear_fade_top_defines.svh"

module sine_tone_with_linear_fade_top
    import stwf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    stwf_in_if.sink            tick,
    stwf_out_if.source         result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t  cfg;
    ctrl_t ctrl;
    stat_t stat;
    pc_t   pc;

    stwf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    stwf_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl),
        .pc    (pc)
    );

    stwf_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .cfg    (cfg),
        .stat   (stat),
        .tick   (tick),
        .result (result)
    );

    `STWF_ASSERT_IMP(a_pc_in_program, 1'b1, pc <= S_LAST)
    `STWF_ASSERT_NXT(a_one_tick_at_a_time, tick.valid && tick.ready, !tick.ready)
    `STWF_ASSERT_IMP(a_finished_is_silent, result.valid && result.finished,
                     result.sample == 16'd0 && !result.last_sample)

endmodule
